/* design/mwdm_pkg.sv */
// Shared types and constants for the mecanum wheel duty mixer.
package mwdm_pkg;

  localparam int unsigned VEL_W = 16;
  localparam int unsigned DUTY_BITS = 10;
  localparam int unsigned CFG_W = 10;
  localparam int unsigned DIR_W = 2;
  localparam int unsigned FRACTION_BITS = 14;
  localparam int unsigned NUM_WHEELS = 4;
  // |f +- l +- r| stays below 2^17
  localparam int unsigned SUM_W = VEL_W + 2;
  localparam int unsigned MAG_W = VEL_W + 1;
  localparam int unsigned MAXS = (1 << DUTY_BITS) - 1;
  localparam logic [CFG_W-1:0] BASE_DUTY_RST = CFG_W'(600);
  localparam logic [CFG_W-1:0] STOP_THR_RST = CFG_W'(10);
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE_DUTY      = 2'd0,
    REG_STOP_THRESHOLD = 2'd1
  } cfg_reg_e;

  typedef enum logic [DIR_W-1:0] {
    DIR_STOP = 2'd0,
    DIR_FWD  = 2'd1,
    DIR_REV  = 2'd2
  } dir_e;

  typedef struct packed {
    logic signed [VEL_W-1:0] forward_velocity;
    logic signed [VEL_W-1:0] lateral_velocity;
    logic signed [VEL_W-1:0] rotation_velocity;
  } cmd_t;

  typedef struct packed {
    logic [DUTY_BITS-1:0] front_left_duty;
    logic [DIR_W-1:0]     front_left_direction;
    logic [DUTY_BITS-1:0] front_right_duty;
    logic [DIR_W-1:0]     front_right_direction;
    logic [DUTY_BITS-1:0] rear_left_duty;
    logic [DIR_W-1:0]     rear_left_direction;
    logic [DUTY_BITS-1:0] rear_right_duty;
    logic [DIR_W-1:0]     rear_right_direction;
  } wheel_out_t;

endpackage

/* design/mwdm_mix.sv */
// Front stages: wheel mixing, magnitudes, peak search and divider operands.
module mwdm_mix #(
  parameter int unsigned FractionBits = mwdm_pkg::FRACTION_BITS,
  localparam int unsigned DenW = (mwdm_pkg::MAG_W > FractionBits + 1) ?
                                 mwdm_pkg::MAG_W : FractionBits + 1,
  localparam int unsigned NumW = mwdm_pkg::MAG_W + mwdm_pkg::DUTY_BITS
) (
  input  logic                                     clk_i,
  input  logic                                     en_i,
  input  mwdm_pkg::cmd_t                           cmd_i,
  output logic [mwdm_pkg::NUM_WHEELS-1:0][NumW-1:0] num_o,
  output logic [DenW-1:0]                          den_o,
  output logic [mwdm_pkg::NUM_WHEELS-1:0]          neg_o
);

  localparam int unsigned SW = mwdm_pkg::SUM_W;
  localparam int unsigned MW = mwdm_pkg::MAG_W;
  localparam logic [NumW-1:0] MaxsN = NumW'(mwdm_pkg::MAXS);
  localparam logic [DenW-1:0] Unity = DenW'(1) << FractionBits;

  logic signed [SW-1:0] f_s, l_s, r_s;
  logic signed [mwdm_pkg::NUM_WHEELS-1:0][SW-1:0] wheel_d, wheel_q;
  logic [mwdm_pkg::NUM_WHEELS-1:0][MW-1:0] mag_d, mag_q;
  logic [mwdm_pkg::NUM_WHEELS-1:0] neg_d, neg_q;
  logic [MW-1:0] max01, max23, peak;
  logic [DenW-1:0] peak_ext;
  logic [mwdm_pkg::NUM_WHEELS-1:0][NumW-1:0] num_d;

  assign f_s = SW'(cmd_i.forward_velocity);
  assign l_s = SW'(cmd_i.lateral_velocity);
  assign r_s = SW'(cmd_i.rotation_velocity);

  // X layout: FL, FR, RL, RR
  assign wheel_d[0] = f_s + l_s + r_s;
  assign wheel_d[1] = f_s - l_s - r_s;
  assign wheel_d[2] = f_s - l_s + r_s;
  assign wheel_d[3] = f_s + l_s - r_s;

  always_comb begin
    for (int i = 0; i < mwdm_pkg::NUM_WHEELS; i++) begin
      neg_d[i] = wheel_q[i][SW-1];
      mag_d[i] = neg_d[i] ? MW'(-wheel_q[i]) : MW'(wheel_q[i]);
    end
  end

  assign max01 = (mag_q[0] > mag_q[1]) ? mag_q[0] : mag_q[1];
  assign max23 = (mag_q[2] > mag_q[3]) ? mag_q[2] : mag_q[3];
  assign peak  = (max01 > max23) ? max01 : max23;
  assign peak_ext = DenW'(peak);

  always_comb begin
    for (int i = 0; i < mwdm_pkg::NUM_WHEELS; i++) begin
      num_d[i] = NumW'(mag_q[i]) * MaxsN;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      wheel_q <= wheel_d;
      mag_q   <= mag_d;
      neg_q   <= neg_d;
      num_o   <= num_d;
      den_o   <= (peak_ext > Unity) ? peak_ext : Unity;
      neg_o   <= neg_q;
    end
  end

endmodule

/* design/mwdm_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
module mwdm_div #(
  parameter int unsigned FractionBits = mwdm_pkg::FRACTION_BITS,
  localparam int unsigned DenW = (mwdm_pkg::MAG_W > FractionBits + 1) ?
                                 mwdm_pkg::MAG_W : FractionBits + 1,
  localparam int unsigned NumW = mwdm_pkg::MAG_W + mwdm_pkg::DUTY_BITS
) (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic [NumW-1:0]                   num_i,
  input  logic [DenW-1:0]                   den_i,
  input  logic                              neg_i,
  output logic [mwdm_pkg::DUTY_BITS-1:0]    q_o,
  output logic                              neg_o
);

  localparam int unsigned D = mwdm_pkg::DUTY_BITS;
  localparam int unsigned W = DenW + D;

  logic [W-1:0]    rem_s [D+1];
  logic [D-1:0]    q_s   [D+1];
  logic [DenW-1:0] den_s [D];
  logic            neg_s [D+1];

  assign rem_s[0] = W'(num_i);
  assign q_s[0]   = '0;
  assign den_s[0] = den_i;
  assign neg_s[0] = neg_i;

  // quotient never exceeds full scale, so D bits cover it
  for (genvar g = 0; g < D; g++) begin : g_stage
    logic [W-1:0] shifted;
    logic         take;
    assign shifted = W'(den_s[g]) << (D - 1 - g);
    assign take    = rem_s[g] >= shifted;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_s[g+1] <= take ? rem_s[g] - shifted : rem_s[g];
        q_s[g+1]   <= {q_s[g][D-2:0], take};
        neg_s[g+1] <= neg_s[g];
      end
    end
    if (g < D - 1) begin : g_den
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          den_s[g+1] <= den_s[g];
        end
      end
    end
  end

  assign q_o   = q_s[D];
  assign neg_o = neg_s[D];

endmodule

/* design/mwdm_duty.sv */
// Back stages: duty scaling onto [base duty, full scale], threshold, direction.
module mwdm_duty (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  logic [mwdm_pkg::DUTY_BITS-1:0]  q_i,
  input  logic                            neg_i,
  input  logic [mwdm_pkg::CFG_W-1:0]      base_duty_i,
  input  logic [mwdm_pkg::CFG_W-1:0]      stop_thr_i,
  output logic [mwdm_pkg::DUTY_BITS-1:0]  duty_o,
  output logic [mwdm_pkg::DIR_W-1:0]      dir_o
);

  localparam int unsigned D = mwdm_pkg::DUTY_BITS;
  localparam int unsigned CW = (D > mwdm_pkg::CFG_W) ? D : mwdm_pkg::CFG_W;
  localparam logic [CW-1:0] MaxsC = CW'(mwdm_pkg::MAXS);
  localparam logic [D-1:0]  MaxsD = D'(mwdm_pkg::MAXS);

  logic [CW-1:0]  min_ext;
  logic [D-1:0]   floor_d, floor_q;
  logic [D-1:0]   span;
  logic [2*D-1:0] prod_d, prod_q;
  logic [D-1:0]   q_q;
  logic           neg_q;
  logic [2*D:0]   recip;
  logic [D-1:0]   scaled;
  logic [D-1:0]   duty_d;
  mwdm_pkg::dir_e dir_d;

  assign min_ext = CW'(base_duty_i);
  assign floor_d = (min_ext > MaxsC) ? MaxsD : D'(min_ext);
  assign span    = MaxsD - floor_d;
  assign prod_d  = (2*D)'(q_i) * (2*D)'(span);

  // x / (2^D - 1) == (x + (x >> D) + 1) >> D for x below 2^(2D) - 1
  assign recip  = (2*D+1)'(prod_q) + (2*D+1)'(prod_q >> D) + (2*D+1)'(1);
  assign scaled = recip[2*D-1:D];

  always_comb begin
    duty_d = '0;
    if (CW'(q_q) > CW'(stop_thr_i)) begin
      duty_d = floor_q + scaled;
    end
    if (q_q == '0) begin
      dir_d = mwdm_pkg::DIR_STOP;
    end else if (neg_q) begin
      dir_d = mwdm_pkg::DIR_REV;
    end else begin
      dir_d = mwdm_pkg::DIR_FWD;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q  <= prod_d;
      floor_q <= floor_d;
      q_q     <= q_i;
      neg_q   <= neg_i;
      duty_o  <= duty_d;
      dir_o   <= dir_d;
    end
  end

endmodule

/* design/mecanum_wheel_duty_mixer_core.sv */
// Commands pass through DUTY_BITS + 5 register stages from input transfer to output valid.
// Throughput: one command per cycle; the whole pipe advances unless the output is stalled.
// Depth is set by the divider, one quotient bit per stage, four wheels in parallel.
// Reset clears valid bits and loads base duty = 600, stop_threshold = 10.
// Config port is always ready; writes land next cycle.
module mecanum_wheel_duty_mixer_core #(
  parameter int unsigned FractionBits = mwdm_pkg::FRACTION_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  mwdm_pkg::cmd_t                      in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output mwdm_pkg::wheel_out_t                out_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [mwdm_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [mwdm_pkg::CFG_W-1:0]          cfg_data_i
);

  localparam int unsigned D = mwdm_pkg::DUTY_BITS;
  localparam int unsigned NW = mwdm_pkg::NUM_WHEELS;
  localparam int unsigned DenW = (mwdm_pkg::MAG_W > FractionBits + 1) ?
                                 mwdm_pkg::MAG_W : FractionBits + 1;
  localparam int unsigned NumW = mwdm_pkg::MAG_W + D;
  // 3 front stages, D divider stages, 2 duty stages
  localparam int unsigned Lat = D + 5;

  logic [Lat-1:0] valid_q;
  logic           advance;

  logic [mwdm_pkg::CFG_W-1:0] base_duty_q, stop_thr_q;

  logic [NW-1:0][NumW-1:0] num;
  logic [DenW-1:0]         den;
  logic [NW-1:0]           neg_mix;
  logic [D-1:0]            quot    [NW];
  logic                    neg_div [NW];
  logic [D-1:0]            duty    [NW];
  logic [mwdm_pkg::DIR_W-1:0] dir  [NW];

  // whole pipe holds while a finished result waits on a stalled output
  assign advance     = !(valid_q[Lat-1] && out_stall_i);
  assign in_stall_o  = !advance;
  assign out_valid_o = valid_q[Lat-1];
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (advance) begin
      valid_q <= {valid_q[Lat-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_duty_q <= mwdm_pkg::BASE_DUTY_RST;
      stop_thr_q  <= mwdm_pkg::STOP_THR_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        mwdm_pkg::REG_BASE_DUTY:      base_duty_q <= cfg_data_i;
        mwdm_pkg::REG_STOP_THRESHOLD: stop_thr_q  <= cfg_data_i;
        default: ;  // unknown index: ignored
      endcase
    end
  end

  mwdm_mix #(.FractionBits(FractionBits)) u_mix (
    .clk_i (clk_i),
    .en_i  (advance),
    .cmd_i (in_data_i),
    .num_o (num),
    .den_o (den),
    .neg_o (neg_mix)
  );

  for (genvar w = 0; w < NW; w++) begin : g_wheel
    mwdm_div #(.FractionBits(FractionBits)) u_div (
      .clk_i (clk_i),
      .en_i  (advance),
      .num_i (num[w]),
      .den_i (den),
      .neg_i (neg_mix[w]),
      .q_o   (quot[w]),
      .neg_o (neg_div[w])
    );

    mwdm_duty u_duty (
      .clk_i       (clk_i),
      .en_i        (advance),
      .q_i         (quot[w]),
      .neg_i       (neg_div[w]),
      .base_duty_i (base_duty_q),
      .stop_thr_i  (stop_thr_q),
      .duty_o      (duty[w]),
      .dir_o       (dir[w])
    );
  end

  assign out_data_o.front_left_duty       = duty[0];
  assign out_data_o.front_left_direction  = dir[0];
  assign out_data_o.front_right_duty      = duty[1];
  assign out_data_o.front_right_direction = dir[1];
  assign out_data_o.rear_left_duty        = duty[2];
  assign out_data_o.rear_left_direction   = dir[2];
  assign out_data_o.rear_right_duty       = duty[3];
  assign out_data_o.rear_right_direction  = dir[3];

endmodule

/* design/mwdm_checker.sv */
// Port-level checks for the duty mixer, bound to the top level.
module mwdm_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_stall_o,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input mwdm_pkg::wheel_out_t out_data_o
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // input side stalls exactly when a result waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (out_valid_o && out_stall_i))
    else $error("input stall does not track output backpressure");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.front_left_direction != 2'd3 &&
                    out_data_o.rear_right_direction != 2'd3)
    else $error("bad direction code");

  // nonzero front-right duty needs a moving wheel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.front_right_duty != '0 |->
      out_data_o.front_right_direction != mwdm_pkg::DIR_STOP)
    else $error("duty without direction");

endmodule

bind mecanum_wheel_duty_mixer_core mwdm_checker u_mwdm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

/* dv/mecanum_wheel_duty_mixer_core_tb.sv */
// Testbench for the mecanum wheel duty mixer: directed and random commands checked against a predictor.
`timescale 1ns / 100ps

module mecanum_wheel_duty_mixer_core_tb;
  import mwdm_pkg::*;

  localparam int unsigned LATENCY = DUTY_BITS + 5;
  localparam longint CYCLE_LIMIT = 400000;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  cmd_t       in_data_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  wheel_out_t out_data_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0]     cfg_data_i = '0;

  // Predictor's copy of the two registers.
  logic [CFG_W-1:0] base_duty_q = BASE_DUTY_RST;
  logic [CFG_W-1:0] stop_thr_q = STOP_THR_RST;

  wheel_out_t expected_wheels[$];
  int         send_idle_pct = 0;
  int         stall_pct = 0;
  int         fail_count = 0;
  longint     cycle_count = 0;

  mecanum_wheel_duty_mixer_core dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Watchdog: the slowest correct run is far below this.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver stall changes on the falling edge.
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // One wheel: scale by the common divisor, clamp, then map onto the duty range.
  function automatic void wheel_drive(input logic signed [SUM_W-1:0] speed,
                                      input longint unsigned divisor,
                                      output logic [DUTY_BITS-1:0] duty,
                                      output logic [DIR_W-1:0] direction);
    longint unsigned mag;
    longint unsigned q;
    longint unsigned floor_duty;
    mag = (speed < 0) ? longint'(-speed) : longint'(speed);
    q = mag * MAXS / divisor;
    if (q > MAXS) q = MAXS;
    floor_duty = (base_duty_q > MAXS) ? MAXS : base_duty_q;
    if (q == 0) direction = DIR_STOP;
    else if (speed > 0) direction = DIR_FWD;
    else direction = DIR_REV;
    if (q > stop_thr_q) duty = DUTY_BITS'(floor_duty + q * (MAXS - floor_duty) / MAXS);
    else duty = '0;
  endfunction

  function automatic wheel_out_t mix_command(input cmd_t cmd);
    logic signed [SUM_W-1:0] w [NUM_WHEELS];
    longint unsigned peak;
    longint unsigned m;
    wheel_out_t res;
    w[0] = SUM_W'(cmd.forward_velocity) + cmd.lateral_velocity + cmd.rotation_velocity;
    w[1] = SUM_W'(cmd.forward_velocity) - cmd.lateral_velocity - cmd.rotation_velocity;
    w[2] = SUM_W'(cmd.forward_velocity) - cmd.lateral_velocity + cmd.rotation_velocity;
    w[3] = SUM_W'(cmd.forward_velocity) + cmd.lateral_velocity - cmd.rotation_velocity;
    peak = 0;
    for (int i = 0; i < NUM_WHEELS; i++) begin
      m = (w[i] < 0) ? longint'(-w[i]) : longint'(w[i]);
      if (m > peak) peak = m;
    end
    if (peak < (64'd1 << FRACTION_BITS)) peak = 64'd1 << FRACTION_BITS;
    wheel_drive(w[0], peak, res.front_left_duty, res.front_left_direction);
    wheel_drive(w[1], peak, res.front_right_duty, res.front_right_direction);
    wheel_drive(w[2], peak, res.rear_left_duty, res.rear_left_direction);
    wheel_drive(w[3], peak, res.rear_right_duty, res.rear_right_direction);
    return res;
  endfunction

  // Output checker: compare each transfer with the oldest expectation.
  always @(posedge clk_i) begin
    wheel_out_t exp_w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_wheels.size() == 0) begin
        $error("unexpected result transfer %h", out_data_o);
        fail_count++;
      end else begin
        exp_w = expected_wheels.pop_front();
        if (exp_w.front_left_duty !== out_data_o.front_left_duty) begin
          $error("front_left_duty exp %0d got %0d", exp_w.front_left_duty,
                 out_data_o.front_left_duty);
          fail_count++;
        end
        if (exp_w.front_left_direction !== out_data_o.front_left_direction) begin
          $error("front_left_direction exp %0d got %0d", exp_w.front_left_direction,
                 out_data_o.front_left_direction);
          fail_count++;
        end
        if (exp_w.front_right_duty !== out_data_o.front_right_duty) begin
          $error("front_right_duty exp %0d got %0d", exp_w.front_right_duty,
                 out_data_o.front_right_duty);
          fail_count++;
        end
        if (exp_w.front_right_direction !== out_data_o.front_right_direction) begin
          $error("front_right_direction exp %0d got %0d", exp_w.front_right_direction,
                 out_data_o.front_right_direction);
          fail_count++;
        end
        if (exp_w.rear_left_duty !== out_data_o.rear_left_duty) begin
          $error("rear_left_duty exp %0d got %0d", exp_w.rear_left_duty,
                 out_data_o.rear_left_duty);
          fail_count++;
        end
        if (exp_w.rear_left_direction !== out_data_o.rear_left_direction) begin
          $error("rear_left_direction exp %0d got %0d", exp_w.rear_left_direction,
                 out_data_o.rear_left_direction);
          fail_count++;
        end
        if (exp_w.rear_right_duty !== out_data_o.rear_right_duty) begin
          $error("rear_right_duty exp %0d got %0d", exp_w.rear_right_duty,
                 out_data_o.rear_right_duty);
          fail_count++;
        end
        if (exp_w.rear_right_direction !== out_data_o.rear_right_direction) begin
          $error("rear_right_direction exp %0d got %0d", exp_w.rear_right_direction,
                 out_data_o.rear_right_direction);
          fail_count++;
        end
      end
    end
  end

  // Sends one command; valid stays up between back-to-back transfers.
  task automatic send_command(input cmd_t cmd);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= cmd;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_wheels.push_back(mix_command(cmd));
    @(negedge clk_i);
  endtask

  task automatic drain_pipe();
    in_valid_i <= 1'b0;
    while (expected_wheels.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 4) @(negedge clk_i);
  endtask

  // Register write while the pipe is empty.
  task automatic write_register(input cfg_reg_e idx, input logic [CFG_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == REG_BASE_DUTY) base_duty_q = value;
    else if (idx == REG_STOP_THRESHOLD) stop_thr_q = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic cmd_t make_cmd(input int f, input int l, input int r);
    cmd_t c;
    c.forward_velocity  = VEL_W'(f);
    c.lateral_velocity  = VEL_W'(l);
    c.rotation_velocity = VEL_W'(r);
    return c;
  endfunction

  // Random commands: mostly within the unit range so the stop band and the
  // linear region get exercised, sometimes full range, sometimes tiny.
  function automatic int rand_vel();
    case ($urandom_range(3))
      0: return $signed(16'($urandom));
      1: return int'($urandom_range(40)) - 20;
      default: return int'($urandom_range(2 * 16384)) - 16384;
    endcase
  endfunction

  task automatic test_directed();
    send_command(make_cmd(0, 0, 0));                // zero speed everywhere
    send_command(make_cmd(32767, 32767, 32767));
    send_command(make_cmd(-32768, -32768, -32768));
    send_command(make_cmd(-32768, 32767, -32768));
    send_command(make_cmd(16384, 0, 0));            // exactly unity
    send_command(make_cmd(16385, 0, 0));            // just above unity
    send_command(make_cmd(0, 16384, 0));
    send_command(make_cmd(0, 0, -16384));
    send_command(make_cmd(100, 0, 0));              // small speed, inside stop band
    send_command(make_cmd(-200, 0, 0));
    send_command(make_cmd(16, 0, 0));               // rounds to zero after scaling
    send_command(make_cmd(8192, 8192, 0));
    send_command(make_cmd(-1, 1, -1));
    send_command(make_cmd(12000, -9000, 3000));
    drain_pipe();
  endtask

  task automatic test_random(input int n);
    for (int i = 0; i < n; i++) send_command(make_cmd(rand_vel(), rand_vel(), rand_vel()));
    drain_pipe();
  endtask

  task automatic test_config_sweep();
    // Extremes: floor at zero, floor at full scale, widest stop band, no stop band.
    write_register(REG_BASE_DUTY, '0);
    write_register(REG_STOP_THRESHOLD, '0);
    test_random(210);
    write_register(REG_BASE_DUTY, 10'd1023);
    write_register(REG_STOP_THRESHOLD, 10'd1023);
    test_random(210);
    write_register(REG_BASE_DUTY, 10'd1023);
    write_register(REG_STOP_THRESHOLD, 10'd512);
    test_random(210);
    write_register(REG_BASE_DUTY, 10'($urandom));
    write_register(REG_STOP_THRESHOLD, 10'($urandom));
    test_random(210);
    write_register(REG_BASE_DUTY, 10'd600);
    write_register(REG_STOP_THRESHOLD, 10'd10);
  endtask

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random(200);                     // no idling
    send_idle_pct = 73;
    test_random(200);
    send_idle_pct = 0;
    stall_pct = 73;
    test_random(200);
    send_idle_pct = 22;
    stall_pct = 22;
    test_random(200);
    send_idle_pct = 0;
    stall_pct = 0;
    test_config_sweep();
    drain_pipe();
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
